### rtl/bgg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the bilinear grid gradient sampler.
package bgg_pkg;

    localparam int NUM_LAYERS_DEF = 4;
    localparam int MAX_GRID_DEF   = 64;

    localparam int OP_W      = 2;
    localparam int LAYER_W   = 2;
    localparam int INDEX_W   = 6;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_CNT_W = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CNT_REGS  = 4;
    localparam int CNT_SEL_W = 2;

    // Operand, product, numerator widths of the gradient arithmetic.
    localparam int OPND_W = DATA_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int NUM_W  = PROD_W + 1;

    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Request operation codes.
    localparam logic [OP_W-1:0] IN_WR_X  = 2'd0;
    localparam logic [OP_W-1:0] IN_WR_Y  = 2'd1;
    localparam logic [OP_W-1:0] IN_WR_F  = 2'd2;
    localparam logic [OP_W-1:0] IN_QUERY = 2'd3;

    // Fetch sequence: the read issued at step k is captured at step k + 1.
    localparam int FETCH_W = 3;
    localparam logic [FETCH_W-1:0] FET_AX_LO  = 3'd0;
    localparam logic [FETCH_W-1:0] FET_AX_HI  = 3'd1;
    localparam logic [FETCH_W-1:0] FET_F11    = 3'd2;
    localparam logic [FETCH_W-1:0] FET_F21    = 3'd3;
    localparam logic [FETCH_W-1:0] FET_F12    = 3'd4;
    localparam logic [FETCH_W-1:0] FET_F22    = 3'd5;
    localparam logic [FETCH_W-1:0] FET_FINAL  = 3'd6;

    // Products formed by the shared multiplier, in order.
    localparam int MUL_W = 3;
    localparam logic [MUL_W-1:0] MUL_DEN  = 3'd0;
    localparam logic [MUL_W-1:0] MUL_GX_A = 3'd1;
    localparam logic [MUL_W-1:0] MUL_GX_B = 3'd2;
    localparam logic [MUL_W-1:0] MUL_GY_A = 3'd3;
    localparam logic [MUL_W-1:0] MUL_GY_B = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_CHECK,
        ST_SRCH_A,
        ST_SRCH_B,
        ST_FETCH,
        ST_WIDTH,
        ST_MUL_LD,
        ST_MUL_RUN,
        ST_MUL_ST,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_FIRST,
        OP_RD_LAST,
        OP_CHECK,
        OP_SRCH_ADDR,
        OP_SRCH_UPD,
        OP_FETCH,
        OP_WIDTH,
        OP_MUL_LD,
        OP_MUL_RUN,
        OP_MUL_ST,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [LAYER_W-1:0]  layer;
        logic [FETCH_W-1:0]  cnt;
        logic [MUL_W-1:0]    mul_idx;
        logic                div_y;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic ok;
        logic search_done;
        logic res_free;
    } dp_stat_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [LAYER_W-1:0]        layer_sel;
        logic [INDEX_W-1:0]        row_index;
        logic [INDEX_W-1:0]        col_index;
        logic signed [DATA_W-1:0]  data_value;
        logic signed [DATA_W-1:0]  query_x;
        logic signed [DATA_W-1:0]  query_y;
    } in_item_t;

    typedef struct packed {
        logic [LAYER_W-1:0]        layer_out;
        logic signed [DATA_W-1:0]  grad_x;
        logic signed [DATA_W-1:0]  grad_y;
        logic                      inside_res;
        logic                      last;
    } out_item_t;

endpackage

### rtl/bgg_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the gradient sampler.
interface bgg_in_if;
    import bgg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [LAYER_W-1:0]        layer_sel;
    logic [INDEX_W-1:0]        row_index;
    logic [INDEX_W-1:0]        col_index;
    logic signed [DATA_W-1:0]  data_value;
    logic signed [DATA_W-1:0]  query_x;
    logic signed [DATA_W-1:0]  query_y;

    modport source (output valid, op, layer_sel, row_index, col_index, data_value,
                    query_x, query_y, input ready);
    modport sink (input valid, op, layer_sel, row_index, col_index, data_value,
                  query_x, query_y, output ready);
endinterface

interface bgg_out_if;
    import bgg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [LAYER_W-1:0]        layer_out;
    logic signed [DATA_W-1:0]  grad_x;
    logic signed [DATA_W-1:0]  grad_y;
    logic                      inside_res;
    logic                      last;

    modport source (output valid, layer_out, grad_x, grad_y, inside_res, last,
                    input ready);
    modport sink (input valid, layer_out, grad_x, grad_y, inside_res, last,
                  output ready);
endinterface

### rtl/bgg_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module bgg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/bgg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the gradient sampler: search, fetch, multiply, divide, emit.
module bgg_ctrl #(
    parameter int NUM_LAYERS = bgg_pkg::NUM_LAYERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output bgg_pkg::dp_cmd_t  cmd,
    input  bgg_pkg::dp_stat_t stat
);
    import bgg_pkg::*;

    ctrl_state_t            state_reg, state_next;
    logic [LAYER_W-1:0]     layer_reg, layer_next;
    logic [FETCH_W-1:0]     cnt_reg, cnt_next;
    logic [MUL_W-1:0]       mul_reg, mul_next;
    logic [DIV_CNT_W-1:0]   div_reg, div_next;
    logic                   final_layer;

    assign final_layer = (int'(layer_reg) == NUM_LAYERS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            layer_reg <= '0;
            cnt_reg   <= '0;
            mul_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            cnt_reg   <= cnt_next;
            mul_reg   <= mul_next;
            div_reg   <= div_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        layer_next  = layer_reg;
        cnt_next    = cnt_reg;
        mul_next    = mul_reg;
        div_next    = div_reg;
        in_ready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.layer   = layer_reg;
        cmd.cnt     = cnt_reg;
        cmd.mul_idx = mul_reg;
        cmd.div_y   = (mul_reg == MUL_GY_B);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (stat.is_query)
                    begin
                        layer_next = '0;
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                cmd.op     = OP_RD_FIRST;
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.op     = OP_RD_LAST;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.op     = OP_CHECK;
                state_next = ST_SRCH_A;
            end
            ST_SRCH_A:
            begin
                if (!stat.ok)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.search_done)
                begin
                    cnt_next   = FET_AX_LO;
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.op     = OP_SRCH_ADDR;
                    state_next = ST_SRCH_B;
                end
            end
            ST_SRCH_B:
            begin
                cmd.op     = OP_SRCH_UPD;
                state_next = ST_SRCH_A;
            end
            ST_FETCH:
            begin
                cmd.op   = OP_FETCH;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FET_FINAL)
                begin
                    state_next = ST_WIDTH;
                end
            end
            ST_WIDTH:
            begin
                cmd.op     = OP_WIDTH;
                mul_next   = MUL_DEN;
                state_next = ST_MUL_LD;
            end
            ST_MUL_LD:
            begin
                if (!stat.ok)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_MUL_LD;
                    state_next = ST_MUL_RUN;
                end
            end
            ST_MUL_RUN:
            begin
                cmd.op     = OP_MUL_RUN;
                state_next = ST_MUL_ST;
            end
            ST_MUL_ST:
            begin
                cmd.op = OP_MUL_ST;
                if (mul_reg == MUL_GX_B || mul_reg == MUL_GY_B)
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    mul_next   = mul_reg + 1'b1;
                    state_next = ST_MUL_LD;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                div_next   = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.op   = OP_DIV_STEP;
                div_next = div_reg + 1'b1;
                if (div_reg == DIV_LAST)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.op = OP_DIV_END;
                if (mul_reg == MUL_GX_B)
                begin
                    mul_next   = MUL_GY_A;
                    state_next = ST_MUL_LD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.res_free)
                begin
                    cmd.op = OP_OUT;
                    if (final_layer)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        layer_next = layer_reg + 1'b1;
                        state_next = ST_FIRST;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_query_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && stat.res_free && final_layer) |=> state_reg == ST_IDLE)
        else $error("query did not return to idle after the final layer");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_STEP && div_reg == DIV_LAST) |=> state_reg == ST_DIV_END)
        else $error("division did not end after its last step");

    a_bad_cell_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_LD && !stat.ok) |=> state_reg == ST_OUT)
        else $error("zero width cell was not sent straight to the output");
`endif
endmodule

### rtl/bgg_dp.sv
`timescale 1ns / 1ps
// Datapath of the gradient sampler: stores, search registers, multiplier and divider.
module bgg_dp #(
    parameter int NUM_LAYERS = bgg_pkg::NUM_LAYERS_DEF,
    parameter int MAX_GRID   = bgg_pkg::MAX_GRID_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bgg_pkg::in_item_t              in_item,
    input  logic                           cfg_wr_en,
    input  logic [bgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgg_pkg::CFG_CNT_W-1:0]  cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output bgg_pkg::out_item_t             out_item,
    input  bgg_pkg::dp_cmd_t               cmd,
    output bgg_pkg::dp_stat_t              stat
);
    import bgg_pkg::*;

    localparam int IDXW = $clog2(MAX_GRID);
    localparam int NW   = IDXW + 1;
    localparam int AXD  = NUM_LAYERS * MAX_GRID;
    localparam int AXW  = $clog2(AXD);
    localparam int SFD  = AXD * MAX_GRID;
    localparam int SFW  = $clog2(SFD);

    logic [CFG_CNT_W-1:0]      xcnt_reg [CNT_REGS];
    logic [CFG_CNT_W-1:0]      ycnt_reg [CNT_REGS];
    logic signed [DATA_W-1:0]  qx_reg, qy_reg;
    logic [IDXW-1:0]           lox_reg, hix_reg, loy_reg, hiy_reg;
    logic                      lowx_reg, lowy_reg, ok_reg;
    logic signed [DATA_W-1:0]  x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [DATA_W-1:0]  f11_reg, f21_reg, f12_reg, f22_reg;
    logic signed [OPND_W-1:0]  mul_a_reg, mul_b_reg;
    logic signed [PROD_W-1:0]  prod_reg, den_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]          rem_reg, dm_reg;
    logic [DATA_W-1:0]         low_reg, q_reg, gx_reg, gy_reg;
    logic                      neg_reg, ovf_reg;
    logic                      out_valid_reg;
    out_item_t                 out_reg;

    logic [NW-1:0]             nx, ny;
    logic                      nx_ok, ny_ok, donex, doney;
    logic [IDXW:0]             sumx, sumy;
    logic [IDXW-1:0]           midx, midy, gapx, gapy;
    logic [IDXW-1:0]           ax_idx, ay_idx, sr_idx, sc_idx;
    logic [AXW-1:0]            xw_addr, yw_addr, xr_addr, yr_addr;
    logic [SFW-1:0]            sw_addr, sr_addr;
    logic                      accept, wx_en, wy_en, wf_en;
    logic signed [DATA_W-1:0]  xdata, ydata, fdata;
    logic signed [OPND_W-1:0]  dx, dy, op_a, op_b;
    logic [NUM_W-1:0]          nm, dm, nm_hi;
    logic [NUM_W:0]            trial;
    logic                      trial_ge;
    logic [DATA_W-1:0]         grad_res;

    assign accept = (cmd.op == OP_ACCEPT);

    // Counts above the grid size behave as the grid size.
    assign nx = (int'(xcnt_reg[cmd.layer]) > MAX_GRID) ? NW'(MAX_GRID)
                                                       : NW'(xcnt_reg[cmd.layer]);
    assign ny = (int'(ycnt_reg[cmd.layer]) > MAX_GRID) ? NW'(MAX_GRID)
                                                       : NW'(ycnt_reg[cmd.layer]);
    assign nx_ok = (nx >= NW'(2));
    assign ny_ok = (ny >= NW'(2));

    assign sumx  = {1'b0, lox_reg} + {1'b0, hix_reg};
    assign sumy  = {1'b0, loy_reg} + {1'b0, hiy_reg};
    assign midx  = sumx[IDXW:1];
    assign midy  = sumy[IDXW:1];
    assign gapx  = hix_reg - lox_reg;
    assign gapy  = hiy_reg - loy_reg;
    assign donex = (gapx <= IDXW'(1));
    assign doney = (gapy <= IDXW'(1));

    // Write side of the stores.
    assign wx_en = accept && in_item.op == IN_WR_X && int'(in_item.layer_sel) < NUM_LAYERS
                   && int'(in_item.row_index) < MAX_GRID;
    assign wy_en = accept && in_item.op == IN_WR_Y && int'(in_item.layer_sel) < NUM_LAYERS
                   && int'(in_item.col_index) < MAX_GRID;
    assign wf_en = accept && in_item.op == IN_WR_F && int'(in_item.layer_sel) < NUM_LAYERS
                   && int'(in_item.row_index) < MAX_GRID
                   && int'(in_item.col_index) < MAX_GRID;
    assign xw_addr = AXW'(int'(in_item.layer_sel) * MAX_GRID + int'(in_item.row_index));
    assign yw_addr = AXW'(int'(in_item.layer_sel) * MAX_GRID + int'(in_item.col_index));
    assign sw_addr = SFW'((int'(in_item.layer_sel) * MAX_GRID + int'(in_item.row_index))
                          * MAX_GRID + int'(in_item.col_index));

    // Read side: axis positions for the search and the cell fetch.
    always_comb
    begin
        ax_idx = '0;
        ay_idx = '0;
        sr_idx = lox_reg;
        sc_idx = loy_reg;
        case (cmd.op)
            OP_RD_LAST:
            begin
                ax_idx = IDXW'(nx - 1'b1);
                ay_idx = IDXW'(ny - 1'b1);
            end
            OP_SRCH_ADDR:
            begin
                ax_idx = midx;
                ay_idx = midy;
            end
            OP_FETCH:
            begin
                if (cmd.cnt == FET_AX_HI)
                begin
                    ax_idx = lox_reg + 1'b1;
                    ay_idx = loy_reg + 1'b1;
                end
                else
                begin
                    ax_idx = lox_reg;
                    ay_idx = loy_reg;
                end
                if (cmd.cnt == FET_F21 || cmd.cnt == FET_F22)
                begin
                    sr_idx = lox_reg + 1'b1;
                end
                if (cmd.cnt == FET_F12 || cmd.cnt == FET_F22)
                begin
                    sc_idx = loy_reg + 1'b1;
                end
            end
            default:
            begin
                ax_idx = '0;
                ay_idx = '0;
            end
        endcase
    end

    assign xr_addr = AXW'(int'(cmd.layer) * MAX_GRID + int'(ax_idx));
    assign yr_addr = AXW'(int'(cmd.layer) * MAX_GRID + int'(ay_idx));
    assign sr_addr = SFW'((int'(cmd.layer) * MAX_GRID + int'(sr_idx)) * MAX_GRID
                          + int'(sc_idx));

    bgg_ram #(.WIDTH(DATA_W), .DEPTH(AXD)) u_x_axis (
        .clk   (clk),
        .we    (wx_en),
        .waddr (xw_addr),
        .wdata (in_item.data_value),
        .raddr (xr_addr),
        .rdata (xdata)
    );

    bgg_ram #(.WIDTH(DATA_W), .DEPTH(AXD)) u_y_axis (
        .clk   (clk),
        .we    (wy_en),
        .waddr (yw_addr),
        .wdata (in_item.data_value),
        .raddr (yr_addr),
        .rdata (ydata)
    );

    bgg_ram #(.WIDTH(DATA_W), .DEPTH(SFD)) u_surface (
        .clk   (clk),
        .we    (wf_en),
        .waddr (sw_addr),
        .wdata (in_item.data_value),
        .raddr (sr_addr),
        .rdata (fdata)
    );

    // Multiplier operands.
    assign dx = OPND_W'(x2_reg) - OPND_W'(x1_reg);
    assign dy = OPND_W'(y2_reg) - OPND_W'(y1_reg);

    always_comb
    begin
        case (cmd.mul_idx)
            MUL_DEN:
            begin
                op_a = dx;
                op_b = dy;
            end
            MUL_GX_A:
            begin
                op_a = OPND_W'(y2_reg) - OPND_W'(qy_reg);
                op_b = OPND_W'(f21_reg) - OPND_W'(f11_reg);
            end
            MUL_GX_B:
            begin
                op_a = OPND_W'(qy_reg) - OPND_W'(y1_reg);
                op_b = OPND_W'(f22_reg) - OPND_W'(f12_reg);
            end
            MUL_GY_A:
            begin
                op_a = OPND_W'(x2_reg) - OPND_W'(qx_reg);
                op_b = OPND_W'(f12_reg) - OPND_W'(f11_reg);
            end
            MUL_GY_B:
            begin
                op_a = OPND_W'(qx_reg) - OPND_W'(x1_reg);
                op_b = OPND_W'(f22_reg) - OPND_W'(f21_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Divider: magnitudes, overflow check and one restoring step per cycle.
    assign nm    = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign dm    = den_reg[PROD_W-1] ? NUM_W'(-den_reg) : NUM_W'(den_reg);
    assign nm_hi = nm >> FRAC_W;
    assign trial    = {rem_reg, low_reg[DATA_W-1]};
    assign trial_ge = (trial >= {1'b0, dm_reg});

    always_comb
    begin
        if (neg_reg)
        begin
            grad_res = (ovf_reg || q_reg > SAT_MIN) ? SAT_MIN : DATA_W'(-q_reg);
        end
        else
        begin
            grad_res = (ovf_reg || q_reg[DATA_W-1]) ? SAT_MAX : q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CNT_REGS; i++)
            begin
                xcnt_reg[i] <= '0;
                ycnt_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (int'(cfg_index) < CNT_REGS)
                begin
                    xcnt_reg[cfg_index[CNT_SEL_W-1:0]] <= cfg_data;
                end
                else if (int'(cfg_index) < 2 * CNT_REGS)
                begin
                    ycnt_reg[cfg_index[CNT_SEL_W-1:0]] <= cfg_data;
                end
            end
            if (cmd.op == OP_CHECK)
            begin
                ok_reg <= nx_ok && ny_ok && !lowx_reg && !lowy_reg
                          && !(qx_reg >= xdata) && !(qy_reg >= ydata);
            end
            else if (cmd.op == OP_WIDTH)
            begin
                ok_reg <= ok_reg && dx != '0 && dy != '0;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                qx_reg <= in_item.query_x;
                qy_reg <= in_item.query_y;
            end
            OP_RD_LAST:
            begin
                lowx_reg <= qx_reg < xdata;
                lowy_reg <= qy_reg < ydata;
            end
            OP_CHECK:
            begin
                lox_reg <= '0;
                loy_reg <= '0;
                hix_reg <= IDXW'(nx - 1'b1);
                hiy_reg <= IDXW'(ny - 1'b1);
            end
            OP_SRCH_UPD:
            begin
                if (!donex)
                begin
                    if (xdata <= qx_reg)
                    begin
                        lox_reg <= midx;
                    end
                    else
                    begin
                        hix_reg <= midx;
                    end
                end
                if (!doney)
                begin
                    if (ydata <= qy_reg)
                    begin
                        loy_reg <= midy;
                    end
                    else
                    begin
                        hiy_reg <= midy;
                    end
                end
            end
            OP_FETCH:
            begin
                case (cmd.cnt)
                    FET_AX_HI:
                    begin
                        x1_reg <= xdata;
                        y1_reg <= ydata;
                    end
                    FET_F11:
                    begin
                        x2_reg <= xdata;
                        y2_reg <= ydata;
                    end
                    FET_F21: f11_reg <= fdata;
                    FET_F12: f21_reg <= fdata;
                    FET_F22: f12_reg <= fdata;
                    FET_FINAL: f22_reg <= fdata;
                    default:
                    begin
                        f22_reg <= f22_reg;
                    end
                endcase
            end
            OP_MUL_LD:
            begin
                mul_a_reg <= op_a;
                mul_b_reg <= op_b;
            end
            OP_MUL_RUN:
            begin
                prod_reg <= mul_a_reg * mul_b_reg;
            end
            OP_MUL_ST:
            begin
                if (cmd.mul_idx == MUL_DEN)
                begin
                    den_reg <= prod_reg;
                end
                else if (cmd.mul_idx == MUL_GX_A || cmd.mul_idx == MUL_GY_A)
                begin
                    num_reg <= NUM_W'(prod_reg);
                end
                else
                begin
                    num_reg <= num_reg + NUM_W'(prod_reg);
                end
            end
            OP_DIV_INIT:
            begin
                // The quotient fits 32 bits exactly when the upper part is below the divisor.
                ovf_reg <= nm_hi >= dm;
                rem_reg <= nm_hi;
                dm_reg  <= dm;
                low_reg <= {nm[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
                neg_reg <= num_reg[NUM_W-1] ^ den_reg[PROD_W-1];
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if (trial_ge)
                begin
                    rem_reg <= NUM_W'(trial - {1'b0, dm_reg});
                end
                else
                begin
                    rem_reg <= trial[NUM_W-1:0];
                end
                q_reg   <= {q_reg[DATA_W-2:0], trial_ge};
                low_reg <= {low_reg[DATA_W-2:0], 1'b0};
            end
            OP_DIV_END:
            begin
                if (cmd.div_y)
                begin
                    gy_reg <= grad_res;
                end
                else
                begin
                    gx_reg <= grad_res;
                end
            end
            OP_OUT:
            begin
                out_reg.layer_out  <= cmd.layer;
                out_reg.grad_x     <= ok_reg ? gx_reg : '0;
                out_reg.grad_y     <= ok_reg ? gy_reg : '0;
                out_reg.inside_res <= ok_reg;
                out_reg.last       <= (int'(cmd.layer) == NUM_LAYERS - 1);
            end
            default:
            begin
                out_reg <= out_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign stat.is_query    = (in_item.op == IN_QUERY);
    assign stat.ok          = ok_reg;
    assign stat.search_done = donex && doney;
    assign stat.res_free    = !out_valid_reg || out_ready;
endmodule

### rtl/bilinear_grid_gradient_top.sv
`timescale 1ns / 1ps
// Top level of the bilinear grid gradient sampler.
//
// Requests arrive on in_ch: x axis, y axis and surface writes fill per-layer
// stores, and a query returns one result per layer on out_ch, layer 0 first,
// with last set on the final layer. Axis counts are set through the cfg port
// (index 0..3 x counts, 4..7 y counts) while no query is in flight; this binds
// the user, as the block itself does not enforce it. A write is accepted while
// the sequencer is idle and produces no result. A query is worked one layer at
// a time by a single sequencer that takes no new request until the last layer
// is issued: it reads and checks the axis ends, runs a binary search (both axes
// searched side by side, at most log2(MAX_GRID) steps), fetches the cell, forms
// five products on the shared 33x33 multiplier and runs two 32-step serial
// divisions. A layer that misses its grid goes straight to its result. The
// serial divider and the single read port of each store bound the query rate.
// Results sit in an output register; while the receiver stalls the block
// holds the next result and waits. Reset clears the counts and the control
// state; store contents are undefined until written.
module bilinear_grid_gradient_top #(
    parameter int NUM_LAYERS = bgg_pkg::NUM_LAYERS_DEF,
    parameter int MAX_GRID   = bgg_pkg::MAX_GRID_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bgg_in_if.sink                         in_ch,
    bgg_out_if.source                      out_ch,
    input  logic                           cfg_wr_en,
    input  logic [bgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgg_pkg::CFG_CNT_W-1:0]  cfg_data
);
    import bgg_pkg::*;

    in_item_t   in_item;
    out_item_t  out_item;
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic       in_ready;
    logic       out_valid;

    assign in_item.op         = in_ch.op;
    assign in_item.layer_sel  = in_ch.layer_sel;
    assign in_item.row_index  = in_ch.row_index;
    assign in_item.col_index  = in_ch.col_index;
    assign in_item.data_value = in_ch.data_value;
    assign in_item.query_x    = in_ch.query_x;
    assign in_item.query_y    = in_ch.query_y;
    assign in_ch.ready        = in_ready;

    bgg_ctrl #(.NUM_LAYERS(NUM_LAYERS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bgg_dp #(.NUM_LAYERS(NUM_LAYERS), .MAX_GRID(MAX_GRID)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign out_ch.valid      = out_valid;
    assign out_ch.layer_out  = out_item.layer_out;
    assign out_ch.grad_x     = out_item.grad_x;
    assign out_ch.grad_y     = out_item.grad_y;
    assign out_ch.inside_res = out_item.inside_res;
    assign out_ch.last       = out_item.last;
endmodule

### test/bilinear_grid_gradient_top_test.sv
`timescale 1ns / 1ps
// Testbench for the bilinear grid gradient sampler: random requests checked against a predictor.
import bgg_pkg::*;

class gradient_scoreboard;
    logic [DATA_W-1:0] x_axis[4][64];
    logic [DATA_W-1:0] y_axis[4][64];
    logic [DATA_W-1:0] surf[4][64][64];
    int unsigned x_cnt[4];
    int unsigned y_cnt[4];
    out_item_t gradients_due[$];
    int errors;

    function new();
        errors = 0;
        for (int k = 0; k < 4; k++)
        begin
            x_cnt[k] = 0;
            y_cnt[k] = 0;
        end
    endfunction

    function void set_count(int idx, int val);
        if (idx < CNT_REGS)
            x_cnt[idx] = val;
        else
            y_cnt[idx - CNT_REGS] = val;
    endfunction

    function longint axis_at(bit on_y, int k, int i);
        return on_y ? longint'($signed(y_axis[k][i])) : longint'($signed(x_axis[k][i]));
    endfunction

    // Cell index found by bisection, or -1 when the point lies outside the axis.
    function int find_cell(bit on_y, int k, int n, longint v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        if (v < axis_at(on_y, k, 0) || v >= axis_at(on_y, k, n - 1))
            return -1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (axis_at(on_y, k, mid) <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function logic signed [127:0] wide_mul(longint a, longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // Quotient times 2^16, truncated toward zero and saturated to 32 bits.
    function logic [DATA_W-1:0] fixed_ratio(logic signed [127:0] num, logic signed [127:0] den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [DATA_W-1:0] t;
        bit neg;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = (n << FRAC_W) / d;
        t = q[DATA_W-1:0];
        if (neg)
            return (q > 128'h8000_0000) ? SAT_MIN : -t;
        return (q > 128'h7FFF_FFFF) ? SAT_MAX : t;
    endfunction

    function void note_request(in_item_t it);
        out_item_t r;
        int nx;
        int ny;
        int ix;
        int iy;
        longint qx;
        longint qy;
        longint x1;
        longint x2;
        longint y1;
        longint y2;
        longint f11;
        longint f21;
        longint f12;
        longint f22;
        logic signed [127:0] den;
        if (it.op == IN_WR_X)
            x_axis[it.layer_sel][it.row_index] = it.data_value;
        else if (it.op == IN_WR_Y)
            y_axis[it.layer_sel][it.col_index] = it.data_value;
        else if (it.op == IN_WR_F)
            surf[it.layer_sel][it.row_index][it.col_index] = it.data_value;
        else
        begin
            qx = it.query_x;
            qy = it.query_y;
            for (int k = 0; k < 4; k++)
            begin
                nx = (x_cnt[k] > 64) ? 64 : x_cnt[k];
                ny = (y_cnt[k] > 64) ? 64 : y_cnt[k];
                r = '0;
                r.layer_out = LAYER_W'(k);
                r.last = (k == 3);
                ix = -1;
                iy = -1;
                if (nx >= 2 && ny >= 2)
                begin
                    ix = find_cell(0, k, nx, qx);
                    iy = find_cell(1, k, ny, qy);
                end
                if (ix >= 0 && iy >= 0)
                begin
                    x1 = axis_at(0, k, ix);
                    x2 = axis_at(0, k, ix + 1);
                    y1 = axis_at(1, k, iy);
                    y2 = axis_at(1, k, iy + 1);
                    if (x2 != x1 && y2 != y1)
                    begin
                        f11 = $signed(surf[k][ix][iy]);
                        f21 = $signed(surf[k][ix + 1][iy]);
                        f12 = $signed(surf[k][ix][iy + 1]);
                        f22 = $signed(surf[k][ix + 1][iy + 1]);
                        den = wide_mul(x2 - x1, y2 - y1);
                        r.grad_x = fixed_ratio(wide_mul(y2 - qy, f21 - f11)
                                               + wide_mul(qy - y1, f22 - f12), den);
                        r.grad_y = fixed_ratio(wide_mul(x2 - qx, f12 - f11)
                                               + wide_mul(qx - x1, f22 - f21), den);
                        r.inside_res = 1'b1;
                    end
                end
                gradients_due.push_back(r);
            end
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (gradients_due.size() == 0)
        begin
            $display("%0t: unexpected result: %p", $time, got);
            errors++;
            return;
        end
        want = gradients_due.pop_front();
        if (got.layer_out !== want.layer_out)
        begin
            $display("%0t: layer_out expected %0d actual %0d", $time, want.layer_out,
                     got.layer_out);
            errors++;
        end
        if (got.grad_x !== want.grad_x)
        begin
            $display("%0t: grad_x layer %0d expected %h actual %h", $time, want.layer_out,
                     want.grad_x, got.grad_x);
            errors++;
        end
        if (got.grad_y !== want.grad_y)
        begin
            $display("%0t: grad_y layer %0d expected %h actual %h", $time, want.layer_out,
                     want.grad_y, got.grad_y);
            errors++;
        end
        if (got.inside_res !== want.inside_res)
        begin
            $display("%0t: inside_res layer %0d expected %b actual %b", $time,
                     want.layer_out, want.inside_res, got.inside_res);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last layer %0d expected %b actual %b", $time, want.layer_out,
                     want.last, got.last);
            errors++;
        end
    endfunction
endclass

module bilinear_grid_gradient_top_test;
    localparam int CYCLE_LIMIT = 900000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_CNT_W-1:0] cfg_data;
    bit gaps_on;
    int cycles;
    int cnt_plan[8];
    gradient_scoreboard sb;

    bgg_in_if in_ch();
    bgg_out_if out_ch();

    bilinear_grid_gradient_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= gaps_on ? ($urandom_range(99) >= 12) : 1'b1;

    // Both sides settle after the rising edge, so the negative edge sees what the next edge takes.
    always @(negedge clk)
    begin
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.layer_out = out_ch.layer_out;
            got.grad_x = out_ch.grad_x;
            got.grad_y = out_ch.grad_y;
            got.inside_res = out_ch.inside_res;
            got.last = out_ch.last;
            sb.check_result(got);
        end
    end

    task automatic send_req(in_item_t it);
        if (gaps_on && $urandom_range(99) < 12)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.layer_sel <= it.layer_sel;
        in_ch.row_index <= it.row_index;
        in_ch.col_index <= it.col_index;
        in_ch.data_value <= it.data_value;
        in_ch.query_x <= it.query_x;
        in_ch.query_y <= it.query_y;
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic write_req(logic [OP_W-1:0] op, int k, int row, int col, longint val);
        in_item_t it;
        it.op = op;
        it.layer_sel = LAYER_W'(k);
        it.row_index = INDEX_W'(row);
        it.col_index = INDEX_W'(col);
        it.data_value = val[DATA_W-1:0];
        it.query_x = $urandom;
        it.query_y = $urandom;
        send_req(it);
    endtask

    task automatic query_req(longint qx, longint qy);
        in_item_t it;
        it.op = IN_QUERY;
        it.layer_sel = LAYER_W'($urandom);
        it.row_index = INDEX_W'($urandom);
        it.col_index = INDEX_W'($urandom);
        it.data_value = $urandom;
        it.query_x = qx[DATA_W-1:0];
        it.query_y = qy[DATA_W-1:0];
        send_req(it);
    endtask

    // Holds the request channel until every gradient is back and the sequencer is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.gradients_due.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic apply_counts();
        for (int i = 0; i < 2 * CNT_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= CFG_CNT_W'(cnt_plan[i]);
            @(posedge clk);
            sb.set_count(i, cnt_plan[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic longint surface_value();
        case ($urandom_range(3))
            0: return $signed($urandom);
            1: return $urandom_range(1) ? longint'(32'sh7FFF_FFFF) : -(longint'(1) << 31);
            default: return longint'($urandom_range(0, 2**21)) - 2**20;
        endcase
    endfunction

    // Fills every axis point and surface entry that the current counts can reach.
    task automatic load_layers();
        int nx;
        int ny;
        longint v;
        for (int k = 0; k < 4; k++)
        begin
            nx = (cnt_plan[k] > 64) ? 64 : cnt_plan[k];
            ny = (cnt_plan[CNT_REGS + k] > 64) ? 64 : cnt_plan[CNT_REGS + k];
            v = longint'($urandom_range(0, 2**25)) - 2**24;
            for (int i = 0; i < nx; i++)
            begin
                write_req(IN_WR_X, k, i, $urandom, v);
                v += $urandom_range(1) ? $urandom_range(1, 2**20) : (1 << $urandom_range(0, 18));
            end
            v = longint'($urandom_range(0, 2**25)) - 2**24;
            for (int j = 0; j < ny; j++)
            begin
                write_req(IN_WR_Y, k, $urandom, j, v);
                v += $urandom_range(1) ? $urandom_range(1, 2**20) : (1 << $urandom_range(0, 18));
            end
            for (int i = 0; i < nx; i++)
                for (int j = 0; j < ny; j++)
                    write_req(IN_WR_F, k, i, j, surface_value());
        end
    endtask

    function automatic longint coord_in(bit on_y, int k);
        int n;
        longint a;
        longint b;
        n = on_y ? cnt_plan[CNT_REGS + k] : cnt_plan[k];
        if (n > 64)
            n = 64;
        if (n < 2 || $urandom_range(9) == 0)
            return $signed($urandom);
        a = sb.axis_at(on_y, k, 0);
        b = sb.axis_at(on_y, k, n - 1);
        if (b <= a)
            return a + $urandom_range(0, 4) - 2;
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? a - $urandom_range(0, 1) : b - $urandom_range(0, 1);
        return a + longint'($urandom) % (b - a);
    endfunction

    task automatic random_items(int n);
        int k;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(3);
            pick = $urandom_range(99);
            if (pick < 50)
                query_req(coord_in(0, k), coord_in(1, k));
            else if (pick < 70)
                write_req(IN_WR_F, k, $urandom_range(1, 8) - 1, $urandom_range(1, 8) - 1,
                          surface_value());
            else if (pick < 78)
                write_req($urandom_range(1) ? IN_WR_X : IN_WR_Y, k, $urandom_range(7),
                          $urandom_range(7), coord_in($urandom_range(1), k));
            else
                write_req(OP_W'($urandom_range(2)), k, $urandom, $urandom, $signed($urandom));
        end
    endtask

    initial
    begin
        longint x0;
        longint y0;
        sb = new();
        cycles = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = IN_WR_X;
        in_ch.layer_sel = '0;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.data_value = '0;
        in_ch.query_x = '0;
        in_ch.query_y = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All counts at reset value zero: every layer misses.
        query_req(0, 0);
        write_req(IN_WR_X, 3, 63, 63, -(longint'(1) << 31));
        write_req(IN_WR_Y, 3, 0, 63, 32'sh7FFF_FFFF);
        write_req(IN_WR_F, 3, 63, 63, -1);
        drain();

        // Widest x axis on layer 0, a two by two layer, a too-short axis and a three by three.
        cnt_plan = '{64, 2, 1, 3, 2, 2, 5, 3};
        apply_counts();
        load_layers();
        x0 = sb.axis_at(0, 3, 0);
        y0 = sb.axis_at(1, 3, 0);
        // Unit cell width with extreme surface steps drives the gradients into saturation.
        write_req(IN_WR_X, 3, 1, 0, x0 + 1);
        write_req(IN_WR_F, 3, 0, 0, -(longint'(1) << 31));
        write_req(IN_WR_F, 3, 1, 0, 32'sh7FFF_FFFF);
        write_req(IN_WR_F, 3, 0, 1, 32'sh7FFF_FFFF);
        write_req(IN_WR_F, 3, 1, 1, -(longint'(1) << 31));
        query_req(x0, y0);
        query_req(x0, sb.axis_at(1, 3, 1) - 1);
        query_req(sb.axis_at(0, 0, 0), sb.axis_at(1, 0, 0));
        query_req(sb.axis_at(0, 0, 63), sb.axis_at(1, 0, 0));
        query_req(sb.axis_at(0, 0, 63) - 1, sb.axis_at(1, 0, 1) - 1);
        query_req(sb.axis_at(0, 0, 0) - 1, sb.axis_at(1, 0, 0));
        query_req(32'sh7FFF_FFFF, -(longint'(1) << 31));
        query_req(-(longint'(1) << 31), 32'sh7FFF_FFFF);
        // A repeated point gives a zero-width cell; a dip breaks the ascending order.
        write_req(IN_WR_X, 1, 1, 0, sb.axis_at(0, 1, 0));
        write_req(IN_WR_X, 0, 31, 0, sb.axis_at(0, 0, 0) - 5);
        query_req(sb.axis_at(0, 1, 0), sb.axis_at(1, 1, 0));
        query_req(sb.axis_at(0, 0, 32), sb.axis_at(1, 0, 0) + 3);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < 2 * CNT_REGS; i++)
                cnt_plan[i] = (ph == 1) ? $urandom_range(2, 4) : $urandom_range(0, 5);
            if (ph == 3)
            begin
                cnt_plan[0] = 0;
                cnt_plan[CNT_REGS + 3] = 1;
            end
            gaps_on = (ph != 1);
            apply_counts();
            load_layers();
            random_items(15);
            drain();
        end

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
